// ===== rtl/ubx_frame_parser_core_defines.svh =====
// assertion macros used by the frame parser checker file
// expects clk and rst_n in the scope of each use
`ifndef UBX_FRAME_PARSER_CORE_DEFINES_SVH
`define UBX_FRAME_PARSER_CORE_DEFINES_SVH

// consequent in the same cycle as the antecedent
`define UBXP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ubxp assertion failed");

// consequent in the cycle after the antecedent
`define UBXP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ubxp assertion failed");

`endif

// ===== rtl/ubxp_pkg.sv =====
// types and codes for the frame parser
// no dependencies
`default_nettype none

package ubxp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [7:0] CLASS_NAV = 8'h01;
  localparam logic [7:0] CLASS_ACK = 8'h05;
  localparam logic [7:0] CLASS_CFG = 8'h06;

  localparam logic [7:0] ID_ACK_NAK     = 8'h00;
  localparam logic [7:0] ID_ACK_ACK     = 8'h01;
  localparam logic [7:0] ID_NAV_POSECEF = 8'h01;
  localparam logic [7:0] ID_NAV_PVT     = 8'h07;
  localparam logic [7:0] ID_CFG_NAV5    = 8'h24;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_GOT_SYNC1   = 4'd1,
    PH_WANT_CLASS  = 4'd2,
    PH_WANT_ID     = 4'd3,
    PH_WANT_LEN_LO = 4'd4,
    PH_WANT_LEN_HI = 4'd5,
    PH_PAYLOAD     = 4'd6,
    PH_WANT_CK_B   = 4'd7
  } phase_t;

  typedef enum logic [3:0] {
    ST_WAIT        = 4'd0,
    ST_TOO_LONG    = 4'd1,
    ST_BAD_SUM     = 4'd2,
    ST_ACK         = 4'd3,
    ST_NAK         = 4'd4,
    ST_NAV_PVT     = 4'd5,
    ST_NAV_POSECEF = 4'd6,
    ST_CFG_NAV5    = 4'd7,
    ST_UNHANDLED   = 4'd8
  } status_t;

  // checksum state handed to the frame check
  typedef struct packed {
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    logic [7:0] check_a;
  } fletcher_t;

endpackage

`default_nettype wire

// ===== rtl/ubxp_check.sv =====
// end of frame check: compares the fletcher sums and classifies the frame
// depends on ubxp_pkg
`default_nettype none

module ubxp_check import ubxp_pkg::*; (
  input  wire logic [7:0] frame_class,
  input  wire logic [7:0] frame_id,
  input  wire fletcher_t  sums,
  input  wire logic [7:0] check_b,
  output status_t         status
);

  status_t kind;

  always_comb begin
    priority if (frame_class == CLASS_ACK) begin
      priority if (frame_id == ID_ACK_NAK) kind = ST_NAK;
      else if (frame_id == ID_ACK_ACK)     kind = ST_ACK;
      else                                 kind = ST_UNHANDLED;
    end else if (frame_class == CLASS_NAV) begin
      priority if (frame_id == ID_NAV_PVT) kind = ST_NAV_PVT;
      else if (frame_id == ID_NAV_POSECEF) kind = ST_NAV_POSECEF;
      else                                 kind = ST_UNHANDLED;
    end else if (frame_class == CLASS_CFG && frame_id == ID_CFG_NAV5) begin
      kind = ST_CFG_NAV5;
    end else begin
      kind = ST_UNHANDLED;
    end
  end

  assign status = (sums.check_a != sums.sum_a || check_b != sums.sum_b) ? ST_BAD_SUM : kind;

endmodule

`default_nettype wire

// ===== rtl/ubx_frame_parser_core.sv =====
// frame parser top level: sync hunt, header capture, running fletcher sum
// depends on ubxp_pkg and ubxp_check
//
//   channel  dir  handshake             word
//   in_      in   in_valid / in_ready   in_rx_byte, one serial byte
//   out_     out  out_valid / out_ready status, payload strobe/offset/data, header
//
// one result word per input word, registered; it appears in the cycle after the word is accepted
// one word per cycle sustained while out_ready is high
// in_ready drops only while a result waits and out_ready is low
// rst_n is synchronous: parser back to sync hunt, header and sums cleared
`default_nettype none

module ubx_frame_parser_core import ubxp_pkg::*; #(
  parameter int MAX_PAYLOAD = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      out_status,
  output logic            out_payload_strobe,
  output logic [6:0]      out_payload_offset,
  output logic [7:0]      out_payload_data,
  output logic [7:0]      out_frame_class,
  output logic [7:0]      out_frame_id,
  output logic [6:0]      out_frame_length
);

  // length register must also hold the raw low length byte
  localparam int LenW = ($clog2(MAX_PAYLOAD) > 8) ? $clog2(MAX_PAYLOAD) : 8;
  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  phase_t         phase_r, phase_nxt;
  logic [7:0]     class_r, class_nxt;
  logic [7:0]     id_r, id_nxt;
  logic [LenW-1:0] length_r, length_nxt;
  logic [LenW-1:0] left_r, left_nxt;
  logic [LenW-1:0] offset_r, offset_nxt;
  logic [7:0]     sum_a_r, sum_a_nxt;
  logic [7:0]     sum_b_r, sum_b_nxt;
  logic [7:0]     check_a_r, check_a_nxt;

  logic           out_valid_r;
  status_t        status_r, status_nxt;
  logic           strobe_r, strobe_nxt;
  logic [6:0]     poff_r, poff_nxt;
  logic [7:0]     pdata_r, pdata_nxt;

  logic           take;
  logic [15:0]    full_len;
  logic           too_long;
  logic           left_zero;
  logic [7:0]     add_a, add_b;
  fletcher_t      sums;
  status_t        end_status;

  assign in_ready  = !out_valid_r || out_ready;
  assign take      = in_valid && in_ready;
  assign full_len  = {in_rx_byte, length_r[7:0]};
  assign too_long  = full_len >= MaxLen;
  assign left_zero = (left_r == '0);
  assign add_a     = sum_a_r + in_rx_byte;
  assign add_b     = sum_b_r + add_a;

  assign sums = '{sum_a: sum_a_r, sum_b: sum_b_r, check_a: check_a_r};

  ubxp_check u_check (
    .frame_class (class_r),
    .frame_id    (id_r),
    .sums        (sums),
    .check_b     (in_rx_byte),
    .status      (end_status)
  );

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      unique case (phase_r)
        PH_IDLE:        if (in_rx_byte == SYNC_FIRST) phase_nxt = PH_GOT_SYNC1;
        PH_GOT_SYNC1:   phase_nxt = (in_rx_byte == SYNC_SECOND) ? PH_WANT_CLASS : PH_IDLE;
        PH_WANT_CLASS:  phase_nxt = PH_WANT_ID;
        PH_WANT_ID:     phase_nxt = PH_WANT_LEN_LO;
        PH_WANT_LEN_LO: phase_nxt = PH_WANT_LEN_HI;
        PH_WANT_LEN_HI: phase_nxt = too_long ? PH_IDLE : PH_PAYLOAD;
        PH_PAYLOAD:     if (left_zero) phase_nxt = PH_WANT_CK_B;
        PH_WANT_CK_B:   phase_nxt = PH_IDLE;
        default:        phase_nxt = PH_IDLE;
      endcase
    end
  end

  // datapath and result word
  always_comb begin
    class_nxt   = class_r;
    id_nxt      = id_r;
    length_nxt  = length_r;
    left_nxt    = left_r;
    offset_nxt  = offset_r;
    sum_a_nxt   = sum_a_r;
    sum_b_nxt   = sum_b_r;
    check_a_nxt = check_a_r;
    status_nxt  = ST_WAIT;
    strobe_nxt  = 1'b0;
    poff_nxt    = '0;
    pdata_nxt   = '0;
    unique case (phase_r)
      PH_IDLE, PH_GOT_SYNC1: begin
      end
      PH_WANT_CLASS: begin
        // sums restart with the class byte
        class_nxt = in_rx_byte;
        sum_a_nxt = in_rx_byte;
        sum_b_nxt = in_rx_byte;
      end
      PH_WANT_ID: begin
        id_nxt    = in_rx_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
      end
      PH_WANT_LEN_LO: begin
        length_nxt = LenW'(in_rx_byte);
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
      end
      PH_WANT_LEN_HI: begin
        length_nxt = full_len[LenW-1:0];
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
        left_nxt   = full_len[LenW-1:0];
        offset_nxt = '0;
        if (too_long) status_nxt = ST_TOO_LONG;
      end
      PH_PAYLOAD: begin
        if (!left_zero) begin
          strobe_nxt = 1'b1;
          poff_nxt   = offset_r[6:0];
          pdata_nxt  = in_rx_byte;
          left_nxt   = left_r - 1'b1;
          offset_nxt = offset_r + 1'b1;
          sum_a_nxt  = add_a;
          sum_b_nxt  = add_b;
        end else begin
          check_a_nxt = in_rx_byte;
        end
      end
      PH_WANT_CK_B: status_nxt = end_status;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      class_r     <= '0;
      id_r        <= '0;
      length_r    <= '0;
      left_r      <= '0;
      offset_r    <= '0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      check_a_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (take) begin
        class_r     <= class_nxt;
        id_r        <= id_nxt;
        length_r    <= length_nxt;
        left_r      <= left_nxt;
        offset_r    <= offset_nxt;
        sum_a_r     <= sum_a_nxt;
        sum_b_r     <= sum_b_nxt;
        check_a_r   <= check_a_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      status_r <= status_nxt;
      strobe_r <= strobe_nxt;
      poff_r   <= poff_nxt;
      pdata_r  <= pdata_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_payload_strobe = strobe_r;
  assign out_payload_offset = poff_r;
  assign out_payload_data   = pdata_r;
  // header fields of the last accepted word
  assign out_frame_class    = class_r;
  assign out_frame_id       = id_r;
  assign out_frame_length   = length_r[6:0];

endmodule

`default_nettype wire

// ===== rtl/ubxp_core_checker.sv =====
// port-level checks on the frame parser, bound to the top level
// depends on ubxp_pkg and ubx_frame_parser_core_defines.svh
`default_nettype none
`include "ubx_frame_parser_core_defines.svh"

module ubxp_core_checker import ubxp_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_rx_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] out_status,
  input wire logic       out_payload_strobe,
  input wire logic [6:0] out_payload_offset,
  input wire logic [7:0] out_payload_data,
  input wire logic [7:0] out_frame_class,
  input wire logic [7:0] out_frame_id,
  input wire logic [6:0] out_frame_length
);

  `UBXP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_payload_data))
  `UBXP_ASSERT_NEXT(a_word_gives_result, in_valid && in_ready, out_valid)
  `UBXP_ASSERT_NOW(a_strobe_no_status, out_valid && out_payload_strobe, out_status == ST_WAIT)
  `UBXP_ASSERT_NOW(a_idle_payload_zero, out_valid && !out_payload_strobe, out_payload_offset == 7'd0 && out_payload_data == 8'd0)

endmodule

bind ubx_frame_parser_core ubxp_core_checker u_ubxp_core_checker (.*);

`default_nettype wire

// ===== tb/sv/ubx_parse_check.sv =====
// result watcher for the frame parser: follows accepted bytes, predicts each result word
// and compares it with what leaves the out_ channel; depends on ubxp_pkg
`timescale 1ns / 100ps

module ubx_parse_check import ubxp_pkg::*; #(
  parameter int MAX_LEN = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] out_status,
  input  logic       out_payload_strobe,
  input  logic [6:0] out_payload_offset,
  input  logic [7:0] out_payload_data,
  input  logic [7:0] out_frame_class,
  input  logic [7:0] out_frame_id,
  input  logic [6:0] out_frame_length,
  output int         mismatches,
  output int         words_due
);

  typedef struct {
    status_t    status;
    logic       strobe;
    logic [6:0] offset;
    logic [7:0] data;
    logic [7:0] cls;
    logic [7:0] id;
    logic [6:0] len;
  } parse_word_t;

  phase_t      phase;
  logic [7:0]  hdr_class;
  logic [7:0]  hdr_id;
  logic [15:0] hdr_len;
  logic [15:0] payload_left;
  logic [7:0]  fl_a;
  logic [7:0]  fl_b;
  logic [7:0]  ck_a_seen;
  int          errs = 0;

  parse_word_t parse_results_due[$];

  initial begin
    mismatches = 0;
    words_due  = 0;
  end

  function automatic void fletcher_add(input logic [7:0] v);
    fl_a = fl_a + v;
    fl_b = fl_b + fl_a;
  endfunction

  function automatic status_t frame_kind();
    case (hdr_class)
      CLASS_ACK: begin
        if (hdr_id == ID_ACK_NAK) return ST_NAK;
        if (hdr_id == ID_ACK_ACK) return ST_ACK;
      end
      CLASS_NAV: begin
        if (hdr_id == ID_NAV_PVT) return ST_NAV_PVT;
        if (hdr_id == ID_NAV_POSECEF) return ST_NAV_POSECEF;
      end
      CLASS_CFG: begin
        if (hdr_id == ID_CFG_NAV5) return ST_CFG_NAV5;
      end
      default: ;
    endcase
    return ST_UNHANDLED;
  endfunction

  function automatic parse_word_t parse_byte(input logic [7:0] b);
    parse_word_t w;
    logic [15:0] pos;
    w.status = ST_WAIT;
    w.strobe = 1'b0;
    w.offset = '0;
    w.data   = '0;
    case (phase)
      PH_IDLE: if (b == SYNC_FIRST) phase = PH_GOT_SYNC1;
      PH_GOT_SYNC1: phase = (b == SYNC_SECOND) ? PH_WANT_CLASS : PH_IDLE;
      PH_WANT_CLASS: begin
        hdr_class = b;
        fl_a = '0;
        fl_b = '0;
        fletcher_add(b);
        phase = PH_WANT_ID;
      end
      PH_WANT_ID: begin
        hdr_id = b;
        fletcher_add(b);
        phase = PH_WANT_LEN_LO;
      end
      PH_WANT_LEN_LO: begin
        hdr_len = {8'h00, b};
        fletcher_add(b);
        phase = PH_WANT_LEN_HI;
      end
      PH_WANT_LEN_HI: begin
        hdr_len[15:8] = b;
        fletcher_add(b);
        if (hdr_len >= MAX_LEN) begin
          w.status = ST_TOO_LONG;
          phase = PH_IDLE;
        end else begin
          payload_left = hdr_len;
          phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (payload_left != 0) begin
          pos = hdr_len - payload_left;
          w.strobe = 1'b1;
          w.offset = pos[6:0];
          w.data = b;
          payload_left = payload_left - 16'd1;
          fletcher_add(b);
        end else begin
          ck_a_seen = b;
          phase = PH_WANT_CK_B;
        end
      end
      PH_WANT_CK_B: begin
        phase = PH_IDLE;
        w.status = (ck_a_seen != fl_a || b != fl_b) ? ST_BAD_SUM : frame_kind();
      end
      default: phase = PH_IDLE;
    endcase
    w.cls = hdr_class;
    w.id  = hdr_id;
    w.len = hdr_len[6:0];
    return w;
  endfunction

  task automatic field_check(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    parse_word_t want;
    if (!rst_n) begin
      phase        = PH_IDLE;
      hdr_class    = '0;
      hdr_id       = '0;
      hdr_len      = '0;
      payload_left = '0;
      fl_a         = '0;
      fl_b         = '0;
      ck_a_seen    = '0;
      parse_results_due.delete();
    end else begin
      // the result word leaving now belongs to an earlier byte, so pop before push
      if (out_valid && out_ready) begin
        if (parse_results_due.size() == 0) begin
          $display("%0t: result word with none due, status %0h", $time, out_status);
          errs++;
        end else begin
          want = parse_results_due.pop_front();
          field_check("status", want.status, out_status);
          field_check("payload_strobe", want.strobe, out_payload_strobe);
          field_check("payload_offset", want.offset, out_payload_offset);
          field_check("payload_data", want.data, out_payload_data);
          field_check("frame_class", want.cls, out_frame_class);
          field_check("frame_id", want.id, out_frame_id);
          field_check("frame_length", want.len, out_frame_length);
        end
      end
      if (in_valid && in_ready) parse_results_due.push_back(parse_byte(in_rx_byte));
    end
    mismatches <= errs;
    words_due  <= parse_results_due.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// top of the frame parser testbench: feeds serial bytes, paces the result side, gives the verdict
// depends on ubxp_pkg, ubx_frame_parser_core and ubx_parse_check
`timescale 1ns / 100ps

module tb import ubxp_pkg::*; ();

  localparam int MAX_LEN     = 128;
  localparam int RAND_BYTES  = 1340;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 60;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_ready  = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [3:0] out_status;
  logic       out_payload_strobe;
  logic [6:0] out_payload_offset;
  logic [7:0] out_payload_data;
  logic [7:0] out_frame_class;
  logic [7:0] out_frame_id;
  logic [6:0] out_frame_length;

  int mismatches;
  int words_due;
  int cycles       = 0;
  int bytes_sent   = 0;
  int holds_asked  = 0;
  int holds_taken  = 0;
  int hold_left    = 0;
  int stall_left   = 0;
  bit quiet        = 1'b0;
  logic [7:0] run_a;
  logic [7:0] run_b;

  always #2 clk = ~clk;

  ubx_frame_parser_core #(.MAX_PAYLOAD(MAX_LEN)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_payload_strobe (out_payload_strobe),
    .out_payload_offset (out_payload_offset),
    .out_payload_data   (out_payload_data),
    .out_frame_class    (out_frame_class),
    .out_frame_id       (out_frame_id),
    .out_frame_length   (out_frame_length)
  );

  ubx_parse_check #(.MAX_LEN(MAX_LEN)) watch (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_payload_strobe (out_payload_strobe),
    .out_payload_offset (out_payload_offset),
    .out_payload_data   (out_payload_data),
    .out_frame_class    (out_frame_class),
    .out_frame_id       (out_frame_id),
    .out_frame_length   (out_frame_length),
    .mismatches         (mismatches),
    .words_due          (words_due)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // result side: short random stalls, plus a long hold when the sender asks for one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_taken != holds_asked) begin
      out_ready   <= 1'b0;
      holds_taken <= holds_taken + 1;
      hold_left   <= LONG_HOLD - 1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic put_summed(input logic [7:0] b);
    run_a = run_a + b;
    run_b = run_b + run_a;
    put_byte(b);
  endtask

  // spoil: 0 clean, 1 corrupt ck_a, 2 corrupt ck_b
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input int spoil);
    logic [7:0] v;
    logic [7:0] flip;
    run_a = '0;
    run_b = '0;
    put_byte(SYNC_FIRST);
    put_byte(SYNC_SECOND);
    put_summed(cls);
    put_summed(id);
    put_summed(len[7:0]);
    put_summed(len[15:8]);
    if (len >= MAX_LEN) return;
    for (int i = 0; i < len; i++) begin
      // sync bytes inside a payload must not restart the parser
      case ($urandom_range(0, 15))
        0:       v = SYNC_FIRST;
        1:       v = SYNC_SECOND;
        default: v = 8'($urandom_range(0, 255));
      endcase
      put_summed(v);
    end
    flip = 8'($urandom_range(1, 255));
    put_byte(spoil == 1 ? run_a ^ flip : run_a);
    put_byte(spoil == 2 ? run_b ^ flip : run_b);
  endtask

  initial begin
    int start;
    int frames;
    int pick;
    logic [7:0] cls;
    logic [7:0] id;
    logic [15:0] len;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // stray bytes and broken sync before any frame
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(SYNC_SECOND);
    put_byte(SYNC_FIRST);
    put_byte(8'h00);
    put_byte(SYNC_FIRST);
    put_byte(SYNC_FIRST);
    put_byte(SYNC_SECOND);
    send_frame(CLASS_ACK, ID_ACK_ACK, 16'd2, 0);
    send_frame(CLASS_ACK, ID_ACK_NAK, 16'd2, 0);
    send_frame(CLASS_NAV, ID_NAV_PVT, 16'd0, 0);
    send_frame(CLASS_NAV, ID_NAV_POSECEF, 16'd1, 0);
    send_frame(CLASS_CFG, ID_CFG_NAV5, 16'd0, 0);
    send_frame(8'hFF, 8'hFF, 16'd0, 0);
    send_frame(CLASS_ACK, 8'h02, 16'd0, 0);
    send_frame(CLASS_NAV, 8'h02, 16'd0, 0);
    send_frame(CLASS_CFG, 8'h00, 16'd0, 0);
    send_frame(CLASS_NAV, ID_NAV_PVT, 16'd3, 1);
    send_frame(CLASS_NAV, ID_NAV_PVT, 16'd3, 2);
    send_frame(CLASS_CFG, ID_CFG_NAV5, 16'(MAX_LEN), 0);
    send_frame(CLASS_CFG, ID_CFG_NAV5, 16'h0100, 0);
    send_frame(8'h00, 8'h00, 16'hFFFF, 0);
    send_frame(CLASS_NAV, ID_NAV_PVT, 16'(MAX_LEN - 1), 0);

    start  = bytes_sent;
    frames = 0;
    while (bytes_sent < start + RAND_BYTES) begin
      if (frames == 15 || frames == 60) holds_asked <= holds_asked + 1;
      if (bytes_sent > start + RAND_BYTES * 85 / 100) quiet = 1'b1;
      frames++;
      case ($urandom_range(0, 6))
        0:       begin cls = CLASS_ACK; id = ID_ACK_ACK;     end
        1:       begin cls = CLASS_ACK; id = ID_ACK_NAK;     end
        2:       begin cls = CLASS_NAV; id = ID_NAV_PVT;     end
        3:       begin cls = CLASS_NAV; id = ID_NAV_POSECEF; end
        4:       begin cls = CLASS_CFG; id = ID_CFG_NAV5;    end
        5:       begin cls = 8'($urandom_range(0, 7)); id = 8'($urandom_range(0, 63)); end
        default: begin cls = 8'($urandom_range(0, 255)); id = 8'($urandom_range(0, 255)); end
      endcase
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, MAX_LEN - 1))
                                        : 16'($urandom_range(0, 12));
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame(cls, id, len, 0);
      end else if (pick < 72) begin
        send_frame(cls, id, len, $urandom_range(1, 2));
      end else if (pick < 78) begin
        send_frame(cls, id, 16'($urandom_range(MAX_LEN, 16'hFFFF)), 0);
      end else if (pick < 86) begin
        put_byte(SYNC_FIRST);
        put_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
